### sv/motor_soft_start_stop_ramp_unit_assert.svh
// Assertion macros shared by the soft start and stop ramp unit.
`ifndef MOTOR_SOFT_START_STOP_RAMP_UNIT_ASSERT_SVH
`define MOTOR_SOFT_START_STOP_RAMP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mssr_pkg.sv
package mssr_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] target_duty;
    logic [15:0] motor_speed;
  } in_t;

  typedef struct packed {
    logic [10:0] pwm_compare;
    logic        motor_enable;
    logic [1:0]  mode;
    logic [9:0]  ramped_duty;
  } out_t;

  // Command codes.
  localparam logic [1:0] KEY_START = 2'd1;
  localparam logic [1:0] KEY_STOP  = 2'd2;

  // Mode codes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_PAUSE = 2'd2;

  // Register indexes.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DUTY_RUN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_DUTY_PAUSE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_DELAY     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_SPEED     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TARGET     = 3'd4;

  // Register reset values.
  localparam logic [7:0]  RST_MIN_DUTY_RUN   = 8'd35;
  localparam logic [7:0]  RST_MIN_DUTY_PAUSE = 8'd20;
  localparam logic [7:0]  RST_RAMP_DELAY     = 8'd20;
  localparam logic [15:0] RST_STOP_SPEED     = 16'd150;
  localparam logic [9:0]  RST_MAX_TARGET     = 10'd600;

endpackage

### sv/motor_soft_start_stop_ramp_unit.sv
// Channel   Ports                          Direction  Payload
// input     in_valid, in_ready, in_data    in         mssr_pkg::in_t (one control tick)
// result    out_valid, out_ready, out_data out        mssr_pkg::out_t (one per tick)
// config    cfg_we, cfg_addr, cfg_wdata    in         five registers, no wait, no read-back
//
// A tick is registered on entry into the stage-one register and evaluated there; its result
// goes to the output register when stage one advances. Unless the output stalls, one tick
// is taken every cycle; the limit is the single evaluation stage feeding the
// output register, which holds a stalled result while the input register takes the next.
// Reset (rst_n, synchronous) clears the mode, ramp state, both stages and restores the
// register defaults. A stall at the output backs up through the input register.

`include "motor_soft_start_stop_ramp_unit_assert.svh"

module motor_soft_start_stop_ramp_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mssr_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mssr_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [mssr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [15:0]                           cfg_wdata
);

  // Phases within run and pause.
  localparam logic       RUN_START   = 1'b0;
  localparam logic       RUN_RAMP    = 1'b1;
  localparam logic [1:0] PAUSE_ENTER = 2'd0;
  localparam logic [1:0] PAUSE_RAMP  = 2'd1;
  localparam logic [1:0] PAUSE_OFF   = 2'd2;

  // Configuration registers.
  logic [7:0]  min_run_r;
  logic [7:0]  min_pause_r;
  logic [7:0]  ramp_delay_r;
  logic [15:0] stop_speed_r;
  logic [9:0]  max_target_r;

  // Ramp state.
  logic [1:0] mode_r, mode_nxt;
  logic       run_phase_r, run_phase_nxt;
  logic [1:0] pause_phase_r, pause_phase_nxt;
  logic [9:0] duty_r, duty_nxt;
  logic [7:0] up_cnt_r, up_cnt_nxt;
  logic [7:0] dn_cnt_r, dn_cnt_nxt;
  logic       drive_on_r, drive_on_nxt;

  // Pipeline stages.
  logic           s1_valid_r;
  mssr_pkg::in_t  s1_data_r;
  logic           out_valid_r;
  mssr_pkg::out_t out_data_r, out_data_nxt;
  logic           s1_adv;

  // Evaluation temporaries.
  logic [9:0]  tgt;
  logic [8:0]  up_inc;
  logic [8:0]  dn_inc;
  logic        up_fire;
  logic        dn_fire;
  logic [1:0]  mode_cmd;
  logic [10:0] pwm;

  // The stage-one tick moves on whenever the output register is empty or being drained,
  // so the input side is only held off by a genuine stall at the output.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_run_r    <= mssr_pkg::RST_MIN_DUTY_RUN;
      min_pause_r  <= mssr_pkg::RST_MIN_DUTY_PAUSE;
      ramp_delay_r <= mssr_pkg::RST_RAMP_DELAY;
      stop_speed_r <= mssr_pkg::RST_STOP_SPEED;
      max_target_r <= mssr_pkg::RST_MAX_TARGET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mssr_pkg::REG_MIN_DUTY_RUN:   min_run_r    <= cfg_wdata[7:0];
        mssr_pkg::REG_MIN_DUTY_PAUSE: min_pause_r  <= cfg_wdata[7:0];
        mssr_pkg::REG_RAMP_DELAY:     ramp_delay_r <= cfg_wdata[7:0];
        mssr_pkg::REG_STOP_SPEED:     stop_speed_r <= cfg_wdata;
        mssr_pkg::REG_MAX_TARGET:     max_target_r <= cfg_wdata[9:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // The whole tick update. The command first decides the mode, then the step of that
  // mode runs in the same tick, exactly once per transfer leaving stage one.
  always_comb begin
    mode_nxt        = mode_r;
    run_phase_nxt   = run_phase_r;
    pause_phase_nxt = pause_phase_r;
    duty_nxt        = duty_r;
    up_cnt_nxt      = up_cnt_r;
    dn_cnt_nxt      = dn_cnt_r;
    drive_on_nxt    = drive_on_r;

    // The target is clipped to the programmed ceiling before any comparison.
    if (s1_data_r.target_duty > {6'd0, max_target_r}) begin
      tgt = max_target_r;
    end else begin
      tgt = s1_data_r.target_duty[9:0];
    end

    // Delay counters are compared in nine bits so that a delay of 255 still fires.
    up_inc  = {1'b0, up_cnt_r} + 9'd1;
    dn_inc  = {1'b0, dn_cnt_r} + 9'd1;
    up_fire = up_inc > {1'b0, ramp_delay_r};
    dn_fire = dn_inc > {1'b0, ramp_delay_r};

    mode_cmd = mode_r;
    if (mode_r == mssr_pkg::MODE_IDLE && s1_data_r.command == mssr_pkg::KEY_START) begin
      mode_cmd      = mssr_pkg::MODE_RUN;
      run_phase_nxt = RUN_START;
    end else if (mode_r == mssr_pkg::MODE_RUN &&
                 s1_data_r.command == mssr_pkg::KEY_STOP) begin
      mode_cmd        = mssr_pkg::MODE_PAUSE;
      pause_phase_nxt = PAUSE_ENTER;
    end
    mode_nxt = mode_cmd;

    if (mode_cmd == mssr_pkg::MODE_RUN) begin
      if (run_phase_nxt == RUN_START) begin
        // Fresh start: drive on at zero duty. The up counter is deliberately kept.
        drive_on_nxt  = 1'b1;
        duty_nxt      = '0;
        run_phase_nxt = RUN_RAMP;
      end else if (tgt > duty_r) begin
        if (up_fire) begin
          up_cnt_nxt = '0;
          duty_nxt   = duty_r + 10'd1;
        end else begin
          up_cnt_nxt = up_inc[7:0];
        end
      end else begin
        if (dn_fire) begin
          dn_cnt_nxt = '0;
          if (tgt < duty_r) begin
            duty_nxt = duty_r - 10'd1;
          end
        end else begin
          dn_cnt_nxt = dn_inc[7:0];
        end
      end
    end else if (mode_cmd == mssr_pkg::MODE_PAUSE) begin
      unique case (pause_phase_nxt)
        PAUSE_ENTER: begin
          pause_phase_nxt = PAUSE_RAMP;
          dn_cnt_nxt      = '0;
        end
        PAUSE_RAMP: begin
          // Ramp to zero first, then wait for the motor to slow below the threshold.
          if (dn_fire) begin
            dn_cnt_nxt = '0;
            if (duty_r != 10'd0) begin
              duty_nxt = duty_r - 10'd1;
            end else if (s1_data_r.motor_speed < stop_speed_r) begin
              pause_phase_nxt = PAUSE_OFF;
            end
          end else begin
            dn_cnt_nxt = dn_inc[7:0];
          end
        end
        PAUSE_OFF: begin
          drive_on_nxt    = 1'b0;
          pause_phase_nxt = PAUSE_ENTER;
          mode_nxt        = mssr_pkg::MODE_IDLE;
        end
        default: begin
          // The spare phase code is never entered and does nothing.
        end
      endcase
    end

    // The compare value adds the minimum of the mode the tick ends in.
    pwm = 11'd0;
    if (drive_on_nxt) begin
      if (mode_nxt == mssr_pkg::MODE_RUN) begin
        pwm = {1'b0, duty_nxt} + {3'd0, min_run_r};
      end else if (mode_nxt == mssr_pkg::MODE_PAUSE) begin
        pwm = {1'b0, duty_nxt} + {3'd0, min_pause_r};
      end else begin
        pwm = {1'b0, duty_nxt};
      end
    end

    out_data_nxt.pwm_compare  = pwm;
    out_data_nxt.motor_enable = drive_on_nxt;
    out_data_nxt.mode         = mode_nxt;
    out_data_nxt.ramped_duty  = duty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      mode_r        <= mssr_pkg::MODE_IDLE;
      run_phase_r   <= RUN_START;
      pause_phase_r <= PAUSE_ENTER;
      duty_r        <= '0;
      up_cnt_r      <= '0;
      dn_cnt_r      <= '0;
      drive_on_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r   <= 1'b1;
        mode_r        <= mode_nxt;
        run_phase_r   <= run_phase_nxt;
        pause_phase_r <= pause_phase_nxt;
        duty_r        <= duty_nxt;
        up_cnt_r      <= up_cnt_nxt;
        dn_cnt_r      <= dn_cnt_nxt;
        drive_on_r    <= drive_on_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A disabled driver always shows a zero compare value.
  `MSSR_ASSERT_NOW(a_off_pwm_zero, out_valid_r && !out_data_r.motor_enable,
    out_data_r.pwm_compare == 11'd0, "pwm_compare non-zero while the driver is off")

  // Idle never leaves the driver switched on.
  `MSSR_ASSERT_NOW(a_idle_drive_off, mode_r == mssr_pkg::MODE_IDLE,
    !drive_on_r, "driver on while idle")

  // The duty moves by at most one per tick, or restarts at zero.
  `MSSR_ASSERT_NEXT(a_duty_step, s1_adv,
    duty_r == $past(duty_r) || duty_r == $past(duty_r) + 10'd1 ||
    duty_r == $past(duty_r) - 10'd1 || duty_r == 10'd0,
    "duty changed by more than one step")

endmodule

### tb/sv/motor_soft_start_stop_ramp_unit_tb.sv
`timescale 1ns / 100ps

module motor_soft_start_stop_ramp_unit_tb;

  // Command codes that the package leaves unnamed: no key event, and the spare
  // code, which the block must treat exactly like no key event.
  localparam logic [1:0] KEY_NONE   = 2'd0;
  localparam logic [1:0] KEY_UNUSED = 2'd3;

  // Steps of the pause sequence: clear the fall counter, ramp down and wait
  // for the motor to slow, then switch the driver off.
  localparam logic [1:0] PAUSE_ENTER = 2'd0;
  localparam logic [1:0] PAUSE_RAMP  = 2'd1;
  localparam logic [1:0] PAUSE_OFF   = 2'd2;

  // Cycle limit for the watchdog, far beyond what a correct run needs.
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  mssr_pkg::in_t                   in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  mssr_pkg::out_t                  out_data;
  logic                            cfg_we    = 1'b0;
  logic [mssr_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [15:0]                     cfg_wdata = '0;

  motor_soft_start_stop_ramp_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Ticks waiting to be driven, and the outputs predicted for accepted ticks,
  // oldest first.
  mssr_pkg::in_t  pending_ticks[$];
  mssr_pkg::out_t expected_outputs[$];

  int unsigned ticks_queued   = 0;
  int unsigned ticks_accepted = 0;
  int unsigned mismatch_total = 0;
  int unsigned cycle_count    = 0;

  // Percentage of cycles in which the driver holds back and the receiver stalls.
  int unsigned src_gap_pct    = 0;
  int unsigned sink_stall_pct = 0;

  // Predictor copy of the register file.
  logic [7:0]  duty_run_offset;
  logic [7:0]  duty_pause_offset;
  logic [7:0]  step_delay;
  logic [15:0] stopped_below;
  logic [9:0]  target_ceiling;

  // Predictor copy of the ramp state.
  logic [1:0]  ramp_mode;
  logic [1:0]  pause_stage;
  logic        run_started;
  logic        drive_live;
  logic [9:0]  duty_now;
  logic [7:0]  rise_count;
  logic [7:0]  fall_count;

  initial begin
    forever #4 clk = ~clk;
  end

  // One tick of a delay counter. The comparison is done in nine bits, so with
  // a delay of 255 the counter fires when it would reach 256, and a counter left
  // above a freshly lowered delay fires on its very next count.
  function automatic bit delay_elapsed(input logic [7:0] count, output logic [7:0] count_next);
    logic [8:0] bumped;
    bumped = {1'b0, count} + 9'd1;
    if (bumped > {1'b0, step_delay}) begin
      count_next = '0;
      return 1'b1;
    end
    count_next = bumped[7:0];
    return 1'b0;
  endfunction

  // Advances the predicted ramp by one accepted tick and returns the output
  // that the block must produce for it.
  function automatic mssr_pkg::out_t ramp_tick(input mssr_pkg::in_t t);
    logic [15:0]    goal;
    mssr_pkg::out_t r;
    goal = (t.target_duty > {6'd0, target_ceiling}) ? {6'd0, target_ceiling} : t.target_duty;

    // The key event may change the mode first; start outside idle, stop outside
    // run and the spare code all fall through without effect.
    if (ramp_mode == mssr_pkg::MODE_IDLE && t.command == mssr_pkg::KEY_START) begin
      run_started = 1'b0;
      ramp_mode   = mssr_pkg::MODE_RUN;
    end else if (ramp_mode == mssr_pkg::MODE_RUN && t.command == mssr_pkg::KEY_STOP) begin
      pause_stage = PAUSE_ENTER;
      ramp_mode   = mssr_pkg::MODE_PAUSE;
    end

    // The step of the (possibly new) mode then runs in the same tick.
    case (ramp_mode)
      mssr_pkg::MODE_RUN: begin
        if (!run_started) begin
          // The rise counter is deliberately left as it was.
          drive_live  = 1'b1;
          duty_now    = '0;
          run_started = 1'b1;
        end else if (goal > {6'd0, duty_now}) begin
          if (delay_elapsed(rise_count, rise_count))
            duty_now = duty_now + 10'd1;
        end else begin
          if (delay_elapsed(fall_count, fall_count) && goal < {6'd0, duty_now})
            duty_now = duty_now - 10'd1;
        end
      end
      mssr_pkg::MODE_PAUSE: begin
        case (pause_stage)
          PAUSE_ENTER: begin
            pause_stage = PAUSE_RAMP;
            fall_count  = '0;
          end
          PAUSE_RAMP: begin
            if (delay_elapsed(fall_count, fall_count)) begin
              if (duty_now != '0)
                duty_now = duty_now - 10'd1;
              else if (t.motor_speed < stopped_below)
                pause_stage = PAUSE_OFF;
            end
          end
          PAUSE_OFF: begin
            drive_live  = 1'b0;
            pause_stage = PAUSE_ENTER;
            ramp_mode   = mssr_pkg::MODE_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    r.pwm_compare = '0;
    if (drive_live) begin
      if (ramp_mode == mssr_pkg::MODE_RUN)
        r.pwm_compare = {1'b0, duty_now} + {3'd0, duty_run_offset};
      else if (ramp_mode == mssr_pkg::MODE_PAUSE)
        r.pwm_compare = {1'b0, duty_now} + {3'd0, duty_pause_offset};
      else
        r.pwm_compare = {1'b0, duty_now};
    end
    r.motor_enable = drive_live;
    r.mode         = ramp_mode;
    r.ramped_duty  = duty_now;
    return r;
  endfunction

  // Driver: offers the next pending tick whenever the channel is free, holding
  // back at random. The prediction is made at the moment of transfer, so it
  // always sees ticks in the order that the block takes them.
  always @(posedge clk) begin : tick_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_outputs.push_back(ramp_tick(in_data));
        ticks_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every result transfer with the oldest prediction, field
  // by field, and stalls the result channel at random.
  always @(posedge clk) begin : output_monitor
    mssr_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $error("result transfer with no tick outstanding");
          mismatch_total++;
        end else begin
          want = expected_outputs.pop_front();
          if (out_data.pwm_compare !== want.pwm_compare) begin
            $error("pwm_compare: expected %0d, got %0d", want.pwm_compare, out_data.pwm_compare);
            mismatch_total++;
          end
          if (out_data.motor_enable !== want.motor_enable) begin
            $error("motor_enable: expected %0d, got %0d", want.motor_enable,
                   out_data.motor_enable);
            mismatch_total++;
          end
          if (out_data.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, out_data.mode);
            mismatch_total++;
          end
          if (out_data.ramped_duty !== want.ramped_duty) begin
            $error("ramped_duty: expected %0d, got %0d", want.ramped_duty, out_data.ramped_duty);
            mismatch_total++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_tick(input logic [1:0] cmd, input logic [15:0] target,
                            input logic [15:0] speed);
    mssr_pkg::in_t t;
    t.command     = cmd;
    t.target_duty = target;
    t.motor_speed = speed;
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  // Mostly targets within reach of the ramp, now and then a full-width value
  // that exercises saturation.
  function automatic logic [15:0] pick_target(input int unsigned span);
    if ($urandom_range(7) == 0)
      return 16'($urandom);
    return 16'($urandom_range(span));
  endfunction

  // Speeds cluster around the stop threshold so that both sides of it are seen.
  function automatic logic [15:0] pick_speed();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return stopped_below;
      2:       return stopped_below - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // The intended key event, occasionally replaced by any code at all.
  function automatic logic [1:0] noisy(input logic [1:0] base);
    if ($urandom_range(9) == 0)
      return 2'($urandom_range(3));
    return base;
  endfunction

  // A well-formed start, ramp, stop and spin-down sequence with random content.
  // The pause stretch is long enough to undo the ramp-up, so most sequences
  // run all the way back to idle.
  task automatic queue_session(input int unsigned span);
    int unsigned run_len;
    int unsigned fall_len;
    run_len  = $urandom_range(30, 5);
    fall_len = run_len + step_delay + $urandom_range(8, 2);
    queue_tick(noisy(mssr_pkg::KEY_START), pick_target(span), pick_speed());
    repeat (run_len) queue_tick(noisy(KEY_NONE), pick_target(span), pick_speed());
    queue_tick(noisy(mssr_pkg::KEY_STOP), pick_target(span), pick_speed());
    repeat (fall_len)
      queue_tick(noisy(KEY_NONE), pick_target(span),
                 ($urandom_range(1) == 0) ? 16'd0 : pick_speed());
  endtask

  // Returns once every queued tick has been transferred and every prediction
  // has been matched by a result.
  task automatic wait_quiet();
    do @(posedge clk);
    while (ticks_accepted != ticks_queued || expected_outputs.size() != 0);
  endtask

  // Registers may only change while the block is idle, so keep stopping and
  // feeding mostly low speeds until the prediction says the motor is off.
  task automatic settle_to_idle();
    wait_quiet();
    while (ramp_mode != mssr_pkg::MODE_IDLE) begin
      repeat (4)
        queue_tick(mssr_pkg::KEY_STOP, 16'($urandom),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0);
      wait_quiet();
    end
  endtask

  // Each register write is taken at the next edge; the write enable is left
  // high between consecutive writes and lowered by the caller.
  task automatic write_reg(input logic [mssr_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    case (addr)
      mssr_pkg::REG_MIN_DUTY_RUN:   duty_run_offset   = value[7:0];
      mssr_pkg::REG_MIN_DUTY_PAUSE: duty_pause_offset = value[7:0];
      mssr_pkg::REG_RAMP_DELAY:     step_delay        = value[7:0];
      mssr_pkg::REG_STOP_SPEED:     stopped_below     = value;
      mssr_pkg::REG_MAX_TARGET:     target_ceiling    = value[9:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] run_offset, input logic [7:0] pause_offset,
                              input logic [7:0] delay, input logic [15:0] stop_spd,
                              input logic [9:0] ceiling);
    write_reg(mssr_pkg::REG_MIN_DUTY_RUN, {8'd0, run_offset});
    write_reg(mssr_pkg::REG_MIN_DUTY_PAUSE, {8'd0, pause_offset});
    write_reg(mssr_pkg::REG_RAMP_DELAY, {8'd0, delay});
    write_reg(mssr_pkg::REG_STOP_SPEED, stop_spd);
    write_reg(mssr_pkg::REG_MAX_TARGET, {6'd0, ceiling});
    cfg_we <= 1'b0;
  endtask

  task automatic play_phase(input int unsigned budget, input int unsigned span);
    int unsigned first;
    first = ticks_queued;
    while (ticks_queued - first < budget) queue_session(span);
    settle_to_idle();
  endtask

  initial begin : stimulus
    // The predictor starts from the state that reset gives the block.
    duty_run_offset   = mssr_pkg::RST_MIN_DUTY_RUN;
    duty_pause_offset = mssr_pkg::RST_MIN_DUTY_PAUSE;
    step_delay        = mssr_pkg::RST_RAMP_DELAY;
    stopped_below     = mssr_pkg::RST_STOP_SPEED;
    target_ceiling    = mssr_pkg::RST_MAX_TARGET;
    ramp_mode         = mssr_pkg::MODE_IDLE;
    pause_stage       = PAUSE_ENTER;
    run_started       = 1'b0;
    drive_live        = 1'b0;
    duty_now          = '0;
    rise_count        = '0;
    fall_count        = '0;

    src_gap_pct    = 20;
    sink_stall_pct = 52;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A short delay keeps the whole cycle of modes within a
    // couple of dozen ticks. Key events that must be ignored come first, then
    // a run with a saturating target that leaves the rise counter at five.
    write_reg(mssr_pkg::REG_RAMP_DELAY, 16'd8);
    cfg_we <= 1'b0;
    queue_tick(KEY_UNUSED, 16'hFFFF, 16'hFFFF);
    queue_tick(mssr_pkg::KEY_STOP, 16'd0, 16'd0);
    queue_tick(KEY_NONE, 16'd600, 16'd150);
    queue_tick(mssr_pkg::KEY_START, 16'hFFFF, 16'hFFFF);
    queue_tick(mssr_pkg::KEY_START, 16'hFFFF, 16'd0);
    queue_tick(KEY_UNUSED, 16'd601, 16'd0);
    queue_tick(KEY_NONE, 16'd600, 16'd0);
    queue_tick(KEY_NONE, 16'd1, 16'd0);
    queue_tick(KEY_NONE, 16'hFFFF, 16'd0);
    // Into pause: start and a repeated stop are both ignored here. The speed
    // stays at or above the threshold until the tick on which the counter fires,
    // which then sees it one below and lets the driver switch off.
    queue_tick(mssr_pkg::KEY_STOP, 16'd0, 16'hFFFF);
    queue_tick(mssr_pkg::KEY_START, 16'd0, 16'hFFFF);
    queue_tick(mssr_pkg::KEY_STOP, 16'd0, 16'hFFFF);
    repeat (5) queue_tick(KEY_NONE, 16'd0, 16'hFFFF);
    queue_tick(KEY_NONE, 16'd0, 16'd150);
    queue_tick(KEY_NONE, 16'd0, 16'd149);
    queue_tick(KEY_NONE, 16'd0, 16'd0);
    wait_quiet();
    // With the delay now below the rise counter left over from the last run,
    // the first count after the next start must fire at once.
    write_reg(mssr_pkg::REG_RAMP_DELAY, 16'd2);
    cfg_we <= 1'b0;
    queue_tick(mssr_pkg::KEY_START, 16'd1, 16'd0);
    queue_tick(KEY_NONE, 16'd1, 16'd0);
    queue_tick(KEY_NONE, 16'd0, 16'd0);
    settle_to_idle();

    // Random part, sender idling lightly and receiver heavily.
    program_regs(8'd0, 8'd255, 8'd0, 16'hFFFF, 10'd1023);
    play_phase(50, 1023);
    program_regs(8'd255, 8'd0, 8'd1, 16'd1000, 10'd0);
    play_phase(40, 40);

    // The other way round.
    src_gap_pct    = 52;
    sink_stall_pct = 20;
    program_regs(8'($urandom), 8'($urandom), 8'($urandom_range(3)),
                 16'($urandom_range(65535, 1)), 10'($urandom_range(1023)));
    play_phase(50, 60);
    program_regs(8'd255, 8'd255, 8'd2, 16'd150, 10'd1023);
    play_phase(40, 1023);

    // No idling at all from here on.
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    program_regs(8'($urandom), 8'($urandom), 8'($urandom_range(4)),
                 16'($urandom_range(65535, 1)), 10'($urandom_range(1023)));
    play_phase(40, 40);

    // Longest delay, where a counter must reach 256 before the duty moves.
    // A stop speed of zero means pause can never end, so this comes last and
    // is not brought back to idle.
    program_regs(mssr_pkg::RST_MIN_DUTY_RUN, mssr_pkg::RST_MIN_DUTY_PAUSE, 8'd255,
                 16'd0, 10'd1023);
    queue_tick(mssr_pkg::KEY_START, pick_target(1023), pick_speed());
    repeat (262)
      queue_tick(($urandom_range(1) == 0) ? KEY_NONE : KEY_UNUSED, pick_target(1023),
                 16'($urandom));
    queue_tick(mssr_pkg::KEY_STOP, pick_target(1023), 16'd0);
    repeat (8) queue_tick(KEY_NONE, pick_target(1023), 16'd0);

    wait_quiet();
    repeat (4) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mssr_pkg.sv
sv/motor_soft_start_stop_ramp_unit.sv
tb/sv/motor_soft_start_stop_ramp_unit_tb.sv
